// ===== rtl/smm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the square matrix multiplier.
// No dependencies; every other file of the block imports this package.
package smm_pkg;

  // Field widths of the request, response and setup beats.
  localparam int ACT_W   = 2;
  localparam int INDEX_W = 4;
  localparam int ORDER_W = 5;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 36;

  // Default bound on the matrix order.
  localparam int DEFAULT_MAX_ORDER = 16;

  // Order register value after reset.
  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;

  // Action codes carried by a request beat.
  localparam logic [ACT_W-1:0] ACT_WR_FIRST  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_SECOND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ      = 2'd3;

  typedef logic [ACT_W-1:0]          action_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [ORDER_W-1:0]        order_t;
  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic signed [2*ELEM_W-1:0] mul_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

endpackage

// ===== rtl/smm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the square matrix multiplier:
// request, response and setup. Depends on smm_pkg for payload types.

// Request channel: one action with its indices and element value.
interface smm_req_if
  import smm_pkg::*;
;
  logic    valid;
  logic    ready;
  action_t action;
  index_t  row_index;
  index_t  column_index;
  elem_t   element_value;

  modport source (output valid, action, row_index, column_index, element_value,
                  input ready);
  modport sink   (input valid, action, row_index, column_index, element_value,
                  output ready);
endinterface

// Response channel: one product entry per beat.
interface smm_rsp_if
  import smm_pkg::*;
;
  logic  valid;
  logic  ready;
  prod_t product_value;

  modport source (output valid, product_value, input ready);
  modport sink   (input valid, product_value, output ready);
endinterface

// Setup channel: writes the matrix order register.
interface smm_cfg_if
  import smm_pkg::*;
;
  logic   valid;
  logic   ready;
  order_t matrix_order;

  modport source (output valid, matrix_order, input ready);
  modport sink   (input valid, matrix_order, output ready);
endinterface

// ===== rtl/square_matrix_multiply.sv =====
`timescale 1ns / 1ps
// Square matrix multiplier, top level: handshakes, order register, product
// memory and read path. Depends on smm_pkg, smm_if and smm_mac_engine.
//
// Usage:
// - setup: one beat writes the matrix order n (0 acts as 1, values above
//   MAX_ORDER act as MAX_ORDER). Always ready; write it only while idle.
// - request: each beat carries an action. Writes of the first or second
//   matrix store one element; compute forms the whole n x n product; read
//   returns one product entry. Writes and reads with an index at or beyond
//   n are dropped and give no response.
// - response: one beat per read in range, through the registered read of
//   the product memory and the output register. Throughput: element writes
// are taken every cycle while request is ready; a read holds ready low
// while in flight. A compute holds it low over one multiply-accumulate per
// cycle on the single shared multiplier, plus the pipeline drain.
// Reset clears the control state and makes every product entry read as zero
// until the first compute; the order returns to 16.
// A stalled response holds its beat; request stays low for a new beat only
// while a compute runs, a response is stalled or a read is in flight.
module square_matrix_multiply
  import smm_pkg::*;
#(
  parameter int MAX_ORDER = DEFAULT_MAX_ORDER
) (
  input logic         clk,
  input logic         rst,
  smm_req_if.sink     request,
  smm_rsp_if.source   response,
  smm_cfg_if.sink     setup
);

  localparam int IDX_W = $clog2(MAX_ORDER);
  localparam int NUM_W = $clog2(MAX_ORDER + 1);
  localparam int DEPTH = 1 << (2 * IDX_W);

  order_t             matrix_order;
  logic [NUM_W-1:0]   n_eff;
  logic [NUM_W-1:0]   prod_order;
  logic               accept;
  logic               in_range;
  logic               start;
  logic               wr_first;
  logic               wr_second;
  logic               rd_go;
  logic [2*IDX_W-1:0] req_addr;
  logic               rd_pend;
  logic               rd_zero;
  prod_t              prod_mem [DEPTH];
  prod_t              prod_rd;
  logic               out_valid;
  prod_t              out_data;
  logic               eng_busy;
  logic               prod_we;
  logic [2*IDX_W-1:0] prod_addr;
  prod_t              prod_data;

  // Order register; the port takes a beat every cycle.
  assign setup.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_order <= ORDER_RESET;
    end else if (setup.valid) begin
      matrix_order <= setup.matrix_order;
    end
  end

  // Order in use, limited to 1 .. MAX_ORDER.
  always_comb begin
    if (matrix_order == '0) begin
      n_eff = NUM_W'(1);
    end else if (int'(matrix_order) > MAX_ORDER) begin
      n_eff = NUM_W'(MAX_ORDER);
    end else begin
      n_eff = NUM_W'(matrix_order);
    end
  end

  // Request decode.
  assign request.ready = !eng_busy && !rd_pend && (!out_valid || response.ready);
  assign accept   = request.valid && request.ready;
  assign in_range = (request.row_index < n_eff) && (request.column_index < n_eff);
  assign req_addr = {IDX_W'(request.row_index), IDX_W'(request.column_index)};
  assign start     = accept && (request.action == ACT_COMPUTE);
  assign wr_first  = accept && in_range && (request.action == ACT_WR_FIRST);
  assign wr_second = accept && in_range && (request.action == ACT_WR_SECOND);
  assign rd_go     = accept && in_range && (request.action == ACT_READ);

  smm_mac_engine #(
    .MAX_ORDER (MAX_ORDER)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .order     (n_eff),
    .wr_first  (wr_first),
    .wr_second (wr_second),
    .wr_addr   (req_addr),
    .wr_data   (request.element_value),
    .busy      (eng_busy),
    .prod_we   (prod_we),
    .prod_addr (prod_addr),
    .prod_data (prod_data)
  );

  // Order of the last compute; entries outside that square read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_order <= '0;
    end else if (start) begin
      prod_order <= n_eff;
    end
  end

  // Product memory: written by the engine, read by request beats.
  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[prod_addr] <= prod_data;
    end
    prod_rd <= prod_mem[req_addr];
  end

  // Read in flight and its zero mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      rd_zero <= (request.row_index >= prod_order) ||
                 (request.column_index >= prod_order);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_data <= rd_zero ? '0 : prod_rd;
    end
  end

  assign response.valid         = out_valid;
  assign response.product_value = out_data;

`ifndef SYNTHESIS
  // Read data never lands on a response beat still waiting.
  a_rd_slot_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("read data arrived while the output register was full");

  // A read is never in flight during a compute.
  a_rd_not_busy: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !eng_busy)
    else $error("read overlaps a compute");

  // Product memory is written only by a running compute.
  a_we_busy: assert property (@(posedge clk) disable iff (rst)
    prod_we |-> eng_busy)
    else $error("product write outside a compute");

  // A compute beat starts the engine in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> eng_busy)
    else $error("compute accepted but engine idle");

  // The stored order of the last compute stays within bounds.
  a_prod_order: assert property (@(posedge clk) disable iff (rst)
    int'(prod_order) <= MAX_ORDER)
    else $error("product order beyond bound");
`endif

endmodule

// ===== rtl/smm_mac_engine.sv =====
`timescale 1ns / 1ps
// Operand memories and the shared multiply-accumulate sequencer that forms
// every product entry of an n x n product. Depends on smm_pkg.
module smm_mac_engine
  import smm_pkg::*;
#(
  parameter int MAX_ORDER = DEFAULT_MAX_ORDER,
  localparam int IDX_W = $clog2(MAX_ORDER),
  localparam int NUM_W = $clog2(MAX_ORDER + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   order,
  input  logic               wr_first,
  input  logic               wr_second,
  input  logic [2*IDX_W-1:0] wr_addr,
  input  elem_t              wr_data,
  output logic               busy,
  output logic               prod_we,
  output logic [2*IDX_W-1:0] prod_addr,
  output prod_t              prod_data
);

  localparam int DEPTH = 1 << (2 * IDX_W);

  // Two guard bits hold the exact sum of up to 64 full-scale products.
  localparam int ACC_W = PROD_W + 2;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam prod_t PROD_MAX = {1'b0, {(PROD_W-1){1'b1}}};
  localparam prod_t PROD_MIN = {1'b1, {(PROD_W-1){1'b0}}};

  localparam logic [1:0] ENG_IDLE  = 2'd0;
  localparam logic [1:0] ENG_RUN   = 2'd1;
  localparam logic [1:0] ENG_DRAIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  elem_t first_mem  [DEPTH];
  elem_t second_mem [DEPTH];

  logic [NUM_W-1:0] n_q;
  logic [NUM_W-1:0] n_last;
  logic [IDX_W-1:0] ci;
  logic [IDX_W-1:0] cj;
  logic [IDX_W-1:0] ck;
  logic             last_i;
  logic             last_j;
  logic             last_k;
  logic             issue;

  // Stage 1: operands read from memory.
  elem_t              a_q;
  elem_t              b_q;
  logic               s1_valid;
  logic               s1_first;
  logic               s1_last;
  logic [2*IDX_W-1:0] s1_addr;

  // Stage 2: registered product.
  mul_t               mul_q;
  logic               s2_valid;
  logic               s2_first;
  logic               s2_last;
  logic [2*IDX_W-1:0] s2_addr;

  acc_t acc;
  acc_t acc_base;
  acc_t acc_next;

  assign n_last = n_q - 1'b1;
  assign last_i = (ci == n_last);
  assign last_j = (cj == n_last);
  assign last_k = (ck == n_last);
  assign issue  = (state == ENG_RUN);
  assign busy   = (state != ENG_IDLE);

  // Operand memories: written from request beats, read by the sequencer.
  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[wr_addr] <= wr_data;
    end
    if (wr_second) begin
      second_mem[wr_addr] <= wr_data;
    end
    a_q <= first_mem[{ci, ck}];
    b_q <= second_mem[{ck, cj}];
  end

  // Sequencer state: run over all (i, j, k), then let the pipeline empty.
  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE: begin
        if (start) begin
          state_next = ENG_RUN;
        end
      end
      ENG_RUN: begin
        if (last_k && last_j && last_i) begin
          state_next = ENG_DRAIN;
        end
      end
      ENG_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = ENG_IDLE;
        end
      end
      default: begin
        state_next = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ENG_IDLE;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // Loop counters: k innermost, then j, then i.
  always_ff @(posedge clk) begin
    if (start && (state == ENG_IDLE)) begin
      n_q <= order;
      ci  <= '0;
      cj  <= '0;
      ck  <= '0;
    end else if (issue) begin
      if (last_k) begin
        ck <= '0;
        if (last_j) begin
          cj <= '0;
          ci <= ci + 1'b1;
        end else begin
          cj <= cj + 1'b1;
        end
      end else begin
        ck <= ck + 1'b1;
      end
    end
  end

  // Pipeline tags and the shared multiplier.
  always_ff @(posedge clk) begin
    s1_first <= (ck == '0);
    s1_last  <= last_k;
    s1_addr  <= {ci, cj};
    mul_q    <= a_q * b_q;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_addr  <= s1_addr;
  end

  // Accumulator. The sum is kept exact and limited only when it is stored.
  assign acc_base = s2_first ? '0 : acc;
  assign acc_next = acc_base + ACC_W'(mul_q);

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= acc_next;
    end
  end

  // The finished sum, saturated to the 36-bit range, goes to the product memory.
  always_comb begin
    if (acc_next > ACC_W'(PROD_MAX)) begin
      prod_data = PROD_MAX;
    end else if (acc_next < ACC_W'(PROD_MIN)) begin
      prod_data = PROD_MIN;
    end else begin
      prod_data = PROD_W'(acc_next);
    end
  end

  assign prod_we   = s2_valid && s2_last;
  assign prod_addr = s2_addr;

endmodule

// ===== sim/square_matrix_multiply_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for square_matrix_multiply. It drives the request and setup
// channels, predicts every product read and checks each response beat against it.
// Depends on smm_pkg, the smm_if channel interfaces and the square_matrix_multiply RTL.
module square_matrix_multiply_tb;
  import smm_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_ORDER    = DEFAULT_MAX_ORDER;
  localparam int ENTRIES      = MAX_ORDER * MAX_ORDER;
  localparam int QUIET_LIMIT  = 40000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 20;
  localparam int PHASES       = 10;
  localparam longint SUM_MAX  = 64'sd34359738367;
  localparam longint SUM_MIN  = -64'sd34359738368;

  // Matrix store, order register and pending product reads, kept in step with the block.
  class product_board;
    elem_t  first_m[ENTRIES];
    elem_t  second_m[ENTRIES];
    bit     first_set[ENTRIES];
    bit     second_set[ENTRIES];
    prod_t  product_m[ENTRIES];
    order_t order_reg;
    prod_t  expected_products[$];
    int     errors;
    int     reads_checked;
    int     computes;

    function new();
      foreach (first_m[e]) begin
        first_m[e]    = '0;
        second_m[e]   = '0;
        first_set[e]  = 1'b0;
        second_set[e] = 1'b0;
        product_m[e]  = '0;
      end
      order_reg     = ORDER_RESET;
      errors        = 0;
      reads_checked = 0;
      computes      = 0;
    endfunction

    // An order of zero acts as one; anything above the bound acts as the bound.
    function int order_in_use();
      if (order_reg == 0) return 1;
      if (order_reg > MAX_ORDER) return MAX_ORDER;
      return int'(order_reg);
    endfunction

    function void set_order(order_t value);
      order_reg = value;
    endfunction

    // True when every operand of an order-n product has been written.
    function bit square_written(int n);
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          if (!first_set[r*MAX_ORDER+c] || !second_set[r*MAX_ORDER+c]) return 1'b0;
      return 1'b1;
    endfunction

    // Q20.16 sums, saturated like the block's, inside the n x n square, zeros everywhere else.
    function void form_product(int n);
      longint acc;
      foreach (product_m[e]) product_m[e] = '0;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          acc = 0;
          for (int k = 0; k < n; k++)
            acc += longint'(first_m[i*MAX_ORDER+k]) * longint'(second_m[k*MAX_ORDER+j]);
          if (acc > SUM_MAX) acc = SUM_MAX;
          if (acc < SUM_MIN) acc = SUM_MIN;
          product_m[i*MAX_ORDER+j] = prod_t'(acc);
        end
      computes++;
    endfunction

    function void note_request(action_t act, index_t row, index_t col, elem_t value);
      int n;
      int at;
      n  = order_in_use();
      at = int'(row) * MAX_ORDER + int'(col);
      if (act == ACT_COMPUTE) begin
        form_product(n);
        return;
      end
      // Writes and reads outside the square are dropped by the block.
      if (int'(row) >= n || int'(col) >= n) return;
      case (act)
        ACT_WR_FIRST: begin
          first_m[at]   = value;
          first_set[at] = 1'b1;
        end
        ACT_WR_SECOND: begin
          second_m[at]   = value;
          second_set[at] = 1'b1;
        end
        default: expected_products.push_back(product_m[at]);
      endcase
    endfunction

    function void check_product(prod_t got);
      prod_t want;
      if (expected_products.size() == 0) begin
        $display("%0t: product beat with no read pending, expected none, actual %0d",
                 $time, got);
        errors++;
        return;
      end
      want = expected_products.pop_front();
      if (got !== want) begin
        $display("%0t: product mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
      reads_checked++;
    endfunction

    function void report_leftover();
      while (expected_products.size() != 0) begin
        $display("%0t: product read never answered, expected %0d, actual none",
                 $time, expected_products.pop_front());
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  smm_req_if req_bus ();
  smm_rsp_if rsp_bus ();
  smm_cfg_if cfg_bus ();

  square_matrix_multiply dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_bus),
    .response (rsp_bus),
    .setup    (cfg_bus)
  );

  product_board board = new();

  bit steady     = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left  = 0;
  int quiet_cycles = 0;
  int beats_sent = 0;
  int orders_used = 1;

  order_t phase_orders[PHASES] = '{5'd3, 5'd2, 5'd5, 5'd31, 5'd4, 5'd1, 5'd7, 5'd0, 5'd16,
                                   5'd6};

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Response side: random stalls, one long hold-off once armed.
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_armed && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 14);
    end
  end

  // Every accepted response beat is checked against the oldest pending read.
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) board.check_product(rsp_bus.product_value);
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no beat moved for %0d cycles", $time, quiet_cycles);
      $display("square_matrix_multiply regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 14);
  endfunction

  // Mostly random Q8.8 values, with the extremes mixed in.
  function automatic elem_t random_element();
    case ($urandom_range(0, 19))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return elem_t'($urandom);
    endcase
  endfunction

  // Offers one request beat and waits until the block takes it.
  task automatic send_request(input action_t act, input index_t row, input index_t col,
                              input elem_t value);
    while (take_gap()) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid         <= 1'b1;
    req_bus.action        <= act;
    req_bus.row_index     <= row;
    req_bus.column_index  <= col;
    req_bus.element_value <= value;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    board.note_request(act, row, col, value);
    beats_sent++;
  endtask

  // Waits out pending reads, then the longest compute at the current order.
  task automatic wait_drained();
    int n;
    while (board.expected_products.size() != 0) @(posedge clk);
    n = board.order_in_use();
    repeat (n * n * n + 8) @(posedge clk);
  endtask

  // Order register write, only while the block is idle.
  task automatic write_order(input order_t value);
    req_bus.valid <= 1'b0;
    wait_drained();
    cfg_bus.valid        <= 1'b1;
    cfg_bus.matrix_order <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    board.set_order(value);
    cfg_bus.valid <= 1'b0;
    orders_used++;
  endtask

  // Writes every operand of the order-n square that has not been written yet.
  task automatic fill_operands(input int n, inout int sent);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        if (!board.first_set[r*MAX_ORDER+c]) begin
          send_request(ACT_WR_FIRST, index_t'(r), index_t'(c), random_element());
          sent++;
        end
        if (!board.second_set[r*MAX_ORDER+c]) begin
          send_request(ACT_WR_SECOND, index_t'(r), index_t'(c), random_element());
          sent++;
        end
      end
  endtask

  // Extreme values, reads after reset, out-of-range indices and the zero-order clamp.
  task automatic run_corner_cases();
    send_request(ACT_READ, 4'd0, 4'd0, '0);
    send_request(ACT_READ, 4'd15, 4'd15, '0);
    send_request(ACT_WR_FIRST, 4'd15, 4'd15, 16'sh7fff);
    write_order(5'd1);
    send_request(ACT_WR_FIRST, 4'd0, 4'd0, 16'sh8000);
    send_request(ACT_WR_SECOND, 4'd0, 4'd0, 16'sh8000);
    send_request(ACT_COMPUTE, 4'd0, 4'd0, '0);
    send_request(ACT_READ, 4'd0, 4'd0, '0);
    send_request(ACT_WR_FIRST, 4'd1, 4'd0, 16'sh1234);
    send_request(ACT_READ, 4'd0, 4'd1, '0);
    send_request(ACT_READ, 4'd15, 4'd15, '0);
    write_order(5'd0);
    send_request(ACT_WR_SECOND, 4'd0, 4'd0, 16'sh7fff);
    send_request(ACT_COMPUTE, 4'd15, 4'd15, 16'shffff);
    send_request(ACT_READ, 4'd0, 4'd0, '0);
    write_order(5'd2);
    send_request(ACT_WR_FIRST, 4'd0, 4'd1, 16'sh7fff);
    send_request(ACT_WR_FIRST, 4'd1, 4'd0, 16'shffff);
    send_request(ACT_WR_FIRST, 4'd1, 4'd1, 16'sh0000);
    send_request(ACT_WR_SECOND, 4'd0, 4'd1, 16'sh0001);
    send_request(ACT_WR_SECOND, 4'd1, 4'd0, 16'sh7fff);
    send_request(ACT_WR_SECOND, 4'd1, 4'd1, 16'sh8000);
    send_request(ACT_COMPUTE, 4'd0, 4'd0, '0);
    send_request(ACT_READ, 4'd1, 4'd1, '0);
    send_request(ACT_READ, 4'd1, 4'd0, '0);
    // Entries outside the last square were cleared by that compute.
    write_order(5'd16);
    send_request(ACT_READ, 4'd15, 4'd15, '0);
  endtask

  // Random writes and reads, mostly in range; a compute first fills missing operands.
  task automatic run_random_phase(input int target);
    int n;
    int sent;
    int pick;
    bit stray;
    index_t row;
    index_t col;
    action_t act;
    n    = board.order_in_use();
    sent = 0;
    while (sent < target) begin
      pick  = $urandom_range(0, 99);
      stray = (n < MAX_ORDER) && ($urandom_range(0, 99) < 12);
      row   = index_t'($urandom_range(0, n - 1));
      col   = index_t'($urandom_range(0, n - 1));
      if (stray) begin
        if ($urandom_range(0, 1)) begin
          row = index_t'($urandom_range(n, MAX_ORDER - 1));
          col = index_t'($urandom_range(0, MAX_ORDER - 1));
        end else begin
          row = index_t'($urandom_range(0, MAX_ORDER - 1));
          col = index_t'($urandom_range(n, MAX_ORDER - 1));
        end
      end
      if (pick >= 92) begin
        if (board.square_written(n)) begin
          send_request(ACT_COMPUTE, row, col, random_element());
          sent++;
        end else begin
          fill_operands(n, sent);
        end
      end else begin
        act = (pick < 30) ? ACT_WR_FIRST : (pick < 55) ? ACT_WR_SECOND : ACT_READ;
        send_request(act, row, col, random_element());
        if (!stray) sent++;
      end
    end
  endtask

  // Main sequence: reset, corner cases, then random phases over several orders.
  initial begin
    rst                   <= 1'b1;
    req_bus.valid         <= 1'b0;
    req_bus.action        <= ACT_WR_FIRST;
    req_bus.row_index     <= '0;
    req_bus.column_index  <= '0;
    req_bus.element_value <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.matrix_order  <= ORDER_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_corner_cases();
    for (int p = 0; p < PHASES; p++) begin
      write_order(phase_orders[p]);
      // The full-size phase carries the long operand fill, driven with no idling.
      steady = (p == 3);
      if (p == 1) hold_armed = 1'b1;
      run_random_phase(PHASE_ITEMS);
    end
    steady = 1'b0;

    req_bus.valid <= 1'b0;
    wait_drained();
    board.report_leftover();
    $display("Sent %0d request beats over %0d order settings, clamped ones included.",
             beats_sent, orders_used);
    $display("Formed %0d products and checked %0d product reads, with %0d mismatches.",
             board.computes, board.reads_checked, board.errors);
    if (board.errors == 0) begin
      $display("square_matrix_multiply regression: pass");
    end else begin
      $display("square_matrix_multiply regression: fail");
    end
    $finish;
  end

endmodule
